>>> hw/rtl/hsl_tinted_alpha_composite_macros.svh
// Assertion macros shared by the checker of the HSL tinted alpha composite block.
// Depends on nothing; included by the checker file.
`ifndef HSL_TINTED_ALPHA_COMPOSITE_MACROS_SVH
`define HSL_TINTED_ALPHA_COMPOSITE_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define HTAC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked at every clock edge, reset included.
`define HTAC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> hw/rtl/htac_pkg.sv
// Package of the HSL tinted alpha composite block: widths, constants, register indexes.
// Depends on nothing; used by the top level and its divider.
package htac_pkg;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam logic [15:0] TINT_HUE_RESET = 16'd5243;
   localparam int CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TINT_HUE = 1'b0,
      CSR_HAS_ALPHA = 1'b1
   } csr_idx_type;
endpackage

>>> hw/rtl/hsl_tinted_alpha_composite.sv
// HSL tinted alpha composite: takes one canvas RGB pixel and one overlay saturation,
// lightness and alpha item per cycle and returns one RGB item per item. Each item
// passes through the pipelined canvas saturation divider followed by
// the blend and HSL-to-RGB multiply stages; the pipe advances whenever its last
// stage is empty or the result is taken, so throughput is one item per cycle.
// Depends on htac_pkg and htac_div.
module hsl_tinted_alpha_composite
   import htac_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // canvas_red, canvas_green, canvas_blue, overlay_saturation, overlay_lightness,
   // overlay_alpha (lowest bits first)
   input  logic [47:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // out_red, out_green, out_blue (lowest bits first)
   output logic [23:0]          rsp_tdata,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);
   localparam int F = FRAC_BITS;
   localparam int W = F + 2;                  // fraction plus headroom for 2l
   localparam int ONE = 1 << F;
   localparam int THIRD = ONE / 3;
   localparam int TWO3 = (2 * ONE) / 3;
   localparam int NUMW = F + 9;               // (mx-mn) << F
   localparam int PRE = 2;                    // stages before the divider
   localparam int DIVL = NUMW + 1;
   localparam int POST = 10;
   localparam int LAT = PRE + DIVL + POST;
   localparam int SIDE = 4 * W + 1;
   // Reciprocal of 255 scaled by 2^(F+16); it never overestimates.
   localparam longint unsigned RCP = (64'd1 << (F + 16)) / 255;

   // Configuration.
   logic [15:0] tint_hue_ff;
   logic        has_alpha_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tint_hue_ff <= TINT_HUE_RESET;
         has_alpha_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_TINT_HUE:  tint_hue_ff <= csr_wdata;
            CSR_HAS_ALPHA: has_alpha_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Pipeline advance: moves when the output register is free or drained.
   logic [LAT-1:0] vld_ff;
   logic           adv;
   assign adv = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
   end
   assign rsp_tvalid = vld_ff[LAT-1];

   // Byte to fraction v*ONE/255: the reciprocal product is at most one short,
   // and one remainder compare brings it up to the exact quotient.
   function automatic logic [W-1:0] b2f(input logic [7:0] v);
      logic [F+8:0] p;
      logic [F+8:0] q;
      begin
         p = (F+9)'(v) << F;
         q = (F+9)'(((F+17)'(v) * (F+17)'(RCP)) >> 16);
         if ((F+9)'(p - (F+9)'(q * 255)) >= (F+9)'(255)) q = q + 1'b1;
         b2f = W'(q);
      end
   endfunction

   // Stage 1: channel extremes and overlay fractions.
   logic [7:0]   mx_ff, mn_ff;
   logic [W-1:0] os1_ff, ol1_ff, a1_ff;
   logic [7:0]   r_in, g_in, b_in, mx_in, mn_in;
   assign r_in = req_tdata[7:0];
   assign g_in = req_tdata[15:8];
   assign b_in = req_tdata[23:16];
   always_comb begin
      mx_in = r_in; mn_in = r_in;
      if (g_in > mx_in) mx_in = g_in;
      if (b_in > mx_in) mx_in = b_in;
      if (g_in < mn_in) mn_in = g_in;
      if (b_in < mn_in) mn_in = b_in;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff <= mx_in; mn_ff <= mn_in;
         os1_ff <= b2f(req_tdata[31:24]);
         ol1_ff <= b2f(req_tdata[39:32]);
         a1_ff <= has_alpha_ff ? b2f(req_tdata[47:40]) : W'(ONE);
      end
   end

   // Stage 2: lightness (sum*ONE/510 = sum/2 as a byte fraction) and divider operands.
   logic [8:0]   sum_w;
   logic [W-1:0] cl2_ff, os2_ff, ol2_ff, a2_ff;
   logic [NUMW-1:0] num2_ff;
   logic [8:0]   den2_ff;
   logic         gray2_ff;
   logic [F+9:0] lp, lq;
   assign sum_w = 9'(mx_ff) + 9'(mn_ff);
   always_comb begin
      // (sum*ONE)/510 via reciprocal of 255 on sum*ONE/2 with remainder fix.
      lp = (F+10)'(sum_w) << (F - 1);
      lq = (F+10)'(((F+18)'(sum_w) * (F+18)'(RCP)) >> 17);
      if ((F+10)'(lp - (F+10)'(lq * 255)) >= (F+10)'(255)) lq = lq + 1'b1;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         cl2_ff <= W'(lq);
         os2_ff <= os1_ff; ol2_ff <= ol1_ff; a2_ff <= a1_ff;
         gray2_ff <= (mx_ff == mn_ff);
         num2_ff <= NUMW'(mx_ff - mn_ff) << F;
         den2_ff <= (sum_w < 9'd255) ? sum_w : 9'(9'd510 - sum_w);
      end
   end

   // Divider, carrying the other operands alongside.
   logic [NUMW-1:0] quo;
   logic [SIDE-1:0] side_out;
   htac_div #(.NUM_W(NUMW), .DEN_W(9), .SIDE_W(SIDE)) u_div (
      .clock(clock), .en(adv), .num(num2_ff),
      .den(gray2_ff ? 9'd1 : den2_ff),
      .side_in({gray2_ff, cl2_ff, os2_ff, ol2_ff, a2_ff}),
      .quo(quo), .side_out(side_out)
   );

   // Post stage 1: canvas saturation and blend differences.
   logic [W-1:0] cs_w, cl_d, os_d, ol_d, a_d;
   logic         gray_d;
   assign {gray_d, cl_d, os_d, ol_d, a_d} = side_out;
   assign cs_w = gray_d ? '0 : W'(quo);
   logic [W-1:0] cs3_ff, cl3_ff, ds3_ff, dl3_ff, a3_ff;
   logic         sup3_ff, lup3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         cs3_ff <= cs_w; cl3_ff <= cl_d; a3_ff <= a_d;
         sup3_ff <= os_d >= cs_w; lup3_ff <= ol_d >= cl_d;
         ds3_ff <= (os_d >= cs_w) ? W'(os_d - cs_w) : W'(cs_w - os_d);
         dl3_ff <= (ol_d >= cl_d) ? W'(ol_d - cl_d) : W'(cl_d - ol_d);
      end
   end

   // Post stage 2: blend products.
   logic [2*W-1:0] ps4_ff, pl4_ff;
   logic [W-1:0]   cs4_ff, cl4_ff;
   logic           sup4_ff, lup4_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ps4_ff <= a3_ff * ds3_ff; pl4_ff <= a3_ff * dl3_ff;
         cs4_ff <= cs3_ff; cl4_ff <= cl3_ff; sup4_ff <= sup3_ff; lup4_ff <= lup3_ff;
      end
   end

   // Post stage 3: blended s and l.
   logic [W-1:0] s5_ff, l5_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s5_ff <= sup4_ff ? W'(cs4_ff + W'(ps4_ff >> F)) : W'(cs4_ff - W'(ps4_ff >> F));
         l5_ff <= lup4_ff ? W'(cl4_ff + W'(pl4_ff >> F)) : W'(cl4_ff - W'(pl4_ff >> F));
      end
   end

   // Post stage 4: product for v2.
   logic [2*W-1:0] p6_ff;
   logic [W-1:0]   s6_ff, l6_ff;
   logic           low6_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         low6_ff <= ((W+1)'(l5_ff) << 1) < (W+1)'(ONE);
         p6_ff <= (((W+1)'(l5_ff) << 1) < (W+1)'(ONE))
                  ? (2*W)'(l5_ff * W'(W'(ONE) + s5_ff)) : (2*W)'(s5_ff * l5_ff);
         s6_ff <= s5_ff; l6_ff <= l5_ff;
      end
   end

   // Post stage 5: v1, v2, wrapped hues.
   logic [W-1:0] v2_w;
   assign v2_w = low6_ff ? W'(p6_ff >> F) : W'(l6_ff + s6_ff - W'(p6_ff >> F));
   logic [W-1:0] v17_ff, sp7_ff, l7_ff;
   logic         gs7_ff;
   logic [W-1:0] v27_ff;
   logic [F:0]   d7_ff [3];
   logic [F+1:0] hh;
   assign hh = (F+2)'((F+16)'(tint_hue_ff) << F >> 16);
   always_ff @(posedge clock) begin
      logic [F+2:0] dr, db;
      if (adv) begin
         dr = (F+3)'(hh) + (F+3)'(THIRD);
         if (dr > (F+3)'(ONE)) dr = dr - (F+3)'(ONE);
         db = (hh >= (F+2)'(THIRD)) ? (F+3)'(hh - (F+2)'(THIRD))
              : (F+3)'((F+3)'(hh) + (F+3)'(ONE) - (F+3)'(THIRD));
         if (db > (F+3)'(ONE)) db = db - (F+3)'(ONE);
         d7_ff[0] <= (F+1)'(dr);
         d7_ff[1] <= (F+1)'(hh > (F+2)'(ONE) ? hh - (F+2)'(ONE) : hh);
         d7_ff[2] <= (F+1)'(db);
         v17_ff <= ((l6_ff << 1) >= v2_w) ? W'((l6_ff << 1) - v2_w) : '0;
         v27_ff <= v2_w;
         sp7_ff <= (v2_w >= W'((l6_ff << 1) >= v2_w ? (l6_ff << 1) - v2_w : 0))
                   ? W'(v2_w - ((l6_ff << 1) >= v2_w ? (l6_ff << 1) - v2_w : 0)) : '0;
         gs7_ff <= (s6_ff == '0);
         l7_ff <= l6_ff;
      end
   end

   // Post stage 6: per channel segment and factor (6d or 6(TWO3-d)).
   logic [1:0]   seg8_ff [3];
   logic [F+3:0] fac8_ff [3];
   logic [W-1:0] v18_ff, v28_ff, sp8_ff, l8_ff;
   logic         gs8_ff;
   for (genvar c = 0; c < 3; c++) begin : g_seg
      logic [F+3:0] d6;
      assign d6 = (F+4)'((F+4)'(d7_ff[c]) * 6);
      always_ff @(posedge clock) begin
         if (adv) begin
            if (d6 < (F+4)'(ONE)) begin
               seg8_ff[c] <= 2'd0; fac8_ff[c] <= d6;
            end else if (((F+2)'(d7_ff[c]) << 1) < (F+2)'(ONE)) begin
               seg8_ff[c] <= 2'd1; fac8_ff[c] <= '0;
            end else if ((F+3)'(d7_ff[c]) * 3 < (F+3)'(2 * ONE)) begin
               seg8_ff[c] <= 2'd2;
               fac8_ff[c] <= (F+4)'((F+4)'(((F+1)'(TWO3) >= d7_ff[c])
                             ? (F+1)'(TWO3) - d7_ff[c] : '0) * 6);
            end else begin
               seg8_ff[c] <= 2'd3; fac8_ff[c] <= '0;
            end
         end
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         v18_ff <= v17_ff; v28_ff <= v27_ff; sp8_ff <= sp7_ff;
         l8_ff <= l7_ff; gs8_ff <= gs7_ff;
      end
   end

   // Post stage 7: span times factor.
   logic [W+F+3:0] pr9_ff [3];
   logic [1:0]     seg9_ff [3];
   logic [W-1:0]   v19_ff, v29_ff, l9_ff;
   logic           gs9_ff;
   for (genvar c = 0; c < 3; c++) begin : g_mul
      always_ff @(posedge clock) begin
         if (adv) begin
            pr9_ff[c] <= sp8_ff * fac8_ff[c];
            seg9_ff[c] <= seg8_ff[c];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         v19_ff <= v18_ff; v29_ff <= v28_ff; l9_ff <= l8_ff; gs9_ff <= gs8_ff;
      end
   end

   // Post stage 8: channel levels.
   logic [W-1:0] lv10_ff [3];
   for (genvar c = 0; c < 3; c++) begin : g_lvl
      always_ff @(posedge clock) begin
         if (adv) begin
            if (gs9_ff) lv10_ff[c] <= l9_ff;
            else begin
               unique case (seg9_ff[c])
                  2'd0, 2'd2: lv10_ff[c] <= W'(v19_ff + W'(pr9_ff[c] >> F));
                  2'd1:       lv10_ff[c] <= v29_ff;
                  default:    lv10_ff[c] <= v19_ff;
               endcase
            end
         end
      end
   end

   // Post stage 9: scale by 255.
   logic [W+7:0] sc11_ff [3];
   for (genvar c = 0; c < 3; c++) begin : g_scl
      always_ff @(posedge clock) begin
         if (adv) sc11_ff[c] <= (W+8)'((W+8)'(lv10_ff[c]) * 255);
      end
   end

   // Post stage 10: truncate and saturate into the output register.
   logic [7:0] out12_ff [3];
   for (genvar c = 0; c < 3; c++) begin : g_out
      logic [W+7:0] v;
      assign v = sc11_ff[c] >> F;
      always_ff @(posedge clock) begin
         if (adv) out12_ff[c] <= (v > (W+8)'(255)) ? 8'hFF : v[7:0];
      end
   end
   assign rsp_tdata = {out12_ff[2], out12_ff[1], out12_ff[0]};
endmodule

>>> hw/rtl/htac_div.sv
// Pipelined restoring divider: quotient of NUM_W-bit dividend by DEN_W-bit divisor.
// Depends on htac_pkg. One quotient bit per stage, one item per cycle, stalls with en.
module htac_div
   import htac_pkg::*;
#(
   parameter int NUM_W = 24,
   parameter int DEN_W = 9,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              en,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic [NUM_W-1:0]  quo,
   output logic [SIDE_W-1:0] side_out
);
   logic [NUM_W-1:0]  q_ff [NUM_W+1];
   logic [DEN_W:0]    r_ff [NUM_W+1];
   logic [DEN_W-1:0]  d_ff [NUM_W+1];
   logic [SIDE_W-1:0] s_ff [NUM_W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff[0] <= num;
         r_ff[0] <= '0;
         d_ff[0] <= den;
         s_ff[0] <= side_in;
      end
   end

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W+1:0] trial_in;
      assign trial_in = {r_ff[k], q_ff[k][NUM_W-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            if (trial_in >= {2'b0, d_ff[k]}) begin
               r_ff[k+1] <= (DEN_W+1)'(trial_in - {2'b0, d_ff[k]});
               q_ff[k+1] <= {q_ff[k][NUM_W-2:0], 1'b1};
            end else begin
               r_ff[k+1] <= trial_in[DEN_W:0];
               q_ff[k+1] <= {q_ff[k][NUM_W-2:0], 1'b0};
            end
            d_ff[k+1] <= d_ff[k];
            s_ff[k+1] <= s_ff[k];
         end
      end
   end

   assign quo = q_ff[NUM_W];
   assign side_out = s_ff[NUM_W];
endmodule

>>> hw/rtl/htac_checker.sv
// Port checker of the HSL tinted alpha composite block, bound to the top level.
// Depends on htac_pkg and the assertion macro header.
`include "hsl_tinted_alpha_composite_macros.svh"
module htac_checker
   import htac_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   `HTAC_ASSERT(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped")
   `HTAC_ASSERT(a_data, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "stalled item changed")
   `HTAC_ASSERT(a_rdy, clock, reset, !rsp_tvalid |-> req_tready, "input stalled while output empty")
   `HTAC_ASSERT_ALWAYS(a_rst, clock, reset |=> !rsp_tvalid, "result after reset")
endmodule

bind hsl_tinted_alpha_composite htac_checker u_htac_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
